// ----- hw/rtl/rod_pkg.sv -----
// ----------------------------------------------------------------------------
// rod_pkg: shared definitions of the rgb ordered dither
// Widths, the 8x8 threshold matrix, level count clamping and the types that
// pass between the top level, the reciprocal unit and the channel lanes.
// ----------------------------------------------------------------------------
package rod_pkg;

    localparam int CH_W       = 8;
    localparam int LVL_W      = 9;
    localparam int DIV_W      = 8;
    localparam int THR_W      = 6;
    localparam int PHASE_W    = 3;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int PROD_SHIFT = 24;
    localparam int RECIP_W    = PROD_SHIFT + 1;
    localparam int STEP_CNT_W = 5;
    localparam int DIV_STEPS  = RECIP_W;

    localparam int DIV_RESET = 5;
    localparam logic [LVL_W-1:0] LEVELS_RESET = LVL_W'(DIV_RESET + 1);
    // ceil(2^24 / spacing divisor) for the reset level count
    localparam logic [RECIP_W-1:0] RECIP_RESET =
        RECIP_W'(((2 ** PROD_SHIFT) + DIV_RESET - 1) / DIV_RESET);

    localparam logic [THR_W-1:0] THRESH [0:7][0:7] = '{
        '{6'd0,  6'd24, 6'd36, 6'd60, 6'd2,  6'd26, 6'd38, 6'd62},
        '{6'd44, 6'd52, 6'd8,  6'd16, 6'd46, 6'd54, 6'd10, 6'd18},
        '{6'd28, 6'd4,  6'd56, 6'd32, 6'd30, 6'd6,  6'd58, 6'd34},
        '{6'd48, 6'd40, 6'd20, 6'd12, 6'd50, 6'd42, 6'd22, 6'd14},
        '{6'd3,  6'd27, 6'd39, 6'd63, 6'd1,  6'd25, 6'd37, 6'd61},
        '{6'd47, 6'd55, 6'd11, 6'd19, 6'd45, 6'd53, 6'd9,  6'd17},
        '{6'd31, 6'd7,  6'd59, 6'd35, 6'd29, 6'd5,  6'd57, 6'd33},
        '{6'd51, 6'd43, 6'd23, 6'd15, 6'd49, 6'd41, 6'd21, 6'd13}
    };

    typedef struct packed {
        logic [DIV_W-1:0]   div;
        logic [RECIP_W-1:0] recip;
    } lane_cfg_t;

    typedef struct packed {
        logic               busy;
        logic [RECIP_W-1:0] recip;
    } recip_stat_t;

    // number of level steps, n-1, with n clamped to 2..256
    function automatic logic [DIV_W-1:0] eff_div(input logic [LVL_W-1:0] n);
        logic [DIV_W-1:0] d;
        if (n < LVL_W'(2))
        begin
            d = DIV_W'(1);
        end
        else if (n > LVL_W'(256))
        begin
            d = DIV_W'(255);
        end
        else
        begin
            d = DIV_W'(n - LVL_W'(1));
        end
        return d;
    endfunction

endpackage

// ----- hw/rtl/rod_pix_if.sv -----
// ----------------------------------------------------------------------------
// rod_pix_if: pixel input channel
// Valid/ready channel carrying one rgb pixel with its matrix position.
// ----------------------------------------------------------------------------
interface rod_pix_if;
    logic                        valid;
    logic                        ready;
    logic [rod_pkg::CH_W-1:0]    red;
    logic [rod_pkg::CH_W-1:0]    green;
    logic [rod_pkg::CH_W-1:0]    blue;
    logic [rod_pkg::ROW_W-1:0]   row;
    logic [rod_pkg::COL_W-1:0]   start_col;
    logic                        first_of_row;

    modport source (
        output valid, red, green, blue, row, start_col, first_of_row,
        input  ready
    );

    modport sink (
        input  valid, red, green, blue, row, start_col, first_of_row,
        output ready
    );
endinterface

// ----- hw/rtl/rod_res_if.sv -----
// ----------------------------------------------------------------------------
// rod_res_if: dithered pixel output channel
// Valid/ready channel carrying one dithered rgb pixel.
// ----------------------------------------------------------------------------
interface rod_res_if;
    logic                     valid;
    logic                     ready;
    logic [rod_pkg::CH_W-1:0] red_out;
    logic [rod_pkg::CH_W-1:0] green_out;
    logic [rod_pkg::CH_W-1:0] blue_out;

    modport source (
        output valid, red_out, green_out, blue_out,
        input  ready
    );

    modport sink (
        input  valid, red_out, green_out, blue_out,
        output ready
    );
endinterface

// ----- hw/rtl/rod_recip.sv -----
// ----------------------------------------------------------------------------
// rod_recip: reciprocal of the level spacing divisor
// Restoring divider, one quotient bit per cycle, giving ceil(2^24 / d) after
// each level count write. Holds busy while it runs.
// ----------------------------------------------------------------------------
module rod_recip (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rod_pkg::DIV_W-1:0]  div,
    output rod_pkg::recip_stat_t       stat
);

    logic                            busy_reg, busy_next;
    logic [rod_pkg::STEP_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [rod_pkg::RECIP_W-1:0]     recip_reg, recip_next;
    logic [rod_pkg::RECIP_W-1:0]     nq_reg, nq_next;
    logic [rod_pkg::DIV_W-1:0]       rem_reg, rem_next;
    logic [rod_pkg::DIV_W-1:0]       div_reg, div_next;
    logic [rod_pkg::DIV_W:0]         rem_sh;
    logic                            ge;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        recip_next = recip_reg;
        nq_next    = nq_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        rem_sh     = {rem_reg, nq_reg[rod_pkg::RECIP_W-1]};
        ge         = rem_sh >= {1'b0, div_reg};
        if (start)
        begin
            // dividend 2^24 + d - 1 gives the rounded-up quotient
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            div_next  = div;
            nq_next   = {1'b1, (rod_pkg::RECIP_W-1)'(div - rod_pkg::DIV_W'(1))};
        end
        else if (busy_reg)
        begin
            rem_next = ge ? rod_pkg::DIV_W'(rem_sh - {1'b0, div_reg})
                          : rod_pkg::DIV_W'(rem_sh);
            nq_next  = {nq_reg[rod_pkg::RECIP_W-2:0], ge};
            cnt_next = cnt_reg + rod_pkg::STEP_CNT_W'(1);
            if (cnt_reg == rod_pkg::STEP_CNT_W'(rod_pkg::DIV_STEPS - 1))
            begin
                busy_next  = 1'b0;
                recip_next = {nq_reg[rod_pkg::RECIP_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            recip_reg <= rod_pkg::RECIP_RESET;
        end
        else
        begin
            busy_reg  <= busy_next;
            cnt_reg   <= cnt_next;
            recip_reg <= recip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.recip = recip_reg;

endmodule

// ----- hw/rtl/rod_lane.sv -----
// ----------------------------------------------------------------------------
// rod_lane: one colour channel of the ordered dither
// Finds the level interval of the channel value, its bounds through the
// spacing reciprocal, and picks the upper or lower level against the
// threshold. Three register stages, then the decision.
// ----------------------------------------------------------------------------
module rod_lane (
    input  logic                       clk,
    input  logic                       en,
    input  rod_pkg::lane_cfg_t         cfg,
    input  logic [rod_pkg::CH_W-1:0]   chan,
    input  logic [rod_pkg::THR_W-1:0]  thr,
    output logic [rod_pkg::CH_W-1:0]   level
);

    // stage a: p = (c+1)*d - 1
    logic [16:0]                 p_full;
    logic [15:0]                 p_a_reg, p_a_next;
    logic [rod_pkg::CH_W-1:0]    c_a_reg;
    logic [rod_pkg::THR_W-1:0]   t_a_reg;
    logic                        sat_a_reg, sat_a_next;

    // stage b: interval index k = p / 255, bounds scaled by 255
    logic [15:0]                 sum_b;
    logic [7:0]                  k_b;
    logic [15:0]                 y0_reg, y0_next;
    logic [15:0]                 y1_reg, y1_next;
    logic [rod_pkg::CH_W-1:0]    c_b_reg;
    logic [rod_pkg::THR_W-1:0]   t_b_reg;
    logic                        sat_b_reg;

    // stage c: lo and hi levels
    logic [31:0]                 lo_prod, hi_prod;
    logic [rod_pkg::CH_W-1:0]    lo_reg, lo_next;
    logic [rod_pkg::CH_W-1:0]    hi_reg, hi_next;
    logic [rod_pkg::CH_W-1:0]    c_c_reg;
    logic [rod_pkg::THR_W-1:0]   t_c_reg;
    logic                        sat_c_reg;

    // decision
    logic [rod_pkg::CH_W-1:0]    span, diff;
    logic [14:0]                 lhs, rhs;
    logic                        pick_hi;

    always_comb
    begin
        p_full     = 17'({1'b0, chan} + 9'd1) * 17'(cfg.div) - 17'd1;
        p_a_next   = p_full[15:0];
        sat_a_next = chan == {rod_pkg::CH_W{1'b1}};

        // exact floor(p / 255) for p up to 65279, the largest p that stage a gives
        sum_b   = p_a_reg + 16'(p_a_reg[15:8]) + 16'd1;
        k_b     = sum_b[15:8];
        y0_next = {k_b, 8'h00} - 16'(k_b);
        y1_next = y0_next + 16'd255;

        lo_prod = 32'(y0_reg) * 32'(cfg.recip);
        hi_prod = 32'(y1_reg) * 32'(cfg.recip);
        lo_next = lo_prod[rod_pkg::PROD_SHIFT +: rod_pkg::CH_W];
        hi_next = hi_prod[rod_pkg::PROD_SHIFT +: rod_pkg::CH_W];

        // extra > t  <=>  64*(c-lo) >= (t+1)*(hi-lo)
        span    = hi_reg - lo_reg;
        diff    = c_c_reg - lo_reg;
        lhs     = {1'b0, diff, 6'b0};
        rhs     = 15'({1'b0, t_c_reg} + 7'd1) * 15'(span);
        pick_hi = lhs >= rhs;
        level   = sat_c_reg ? {rod_pkg::CH_W{1'b1}} : (pick_hi ? hi_reg : lo_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_a_reg   <= p_a_next;
            c_a_reg   <= chan;
            t_a_reg   <= thr;
            sat_a_reg <= sat_a_next;

            y0_reg    <= y0_next;
            y1_reg    <= y1_next;
            c_b_reg   <= c_a_reg;
            t_b_reg   <= t_a_reg;
            sat_b_reg <= sat_a_reg;

            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            c_c_reg   <= c_b_reg;
            t_c_reg   <= t_b_reg;
            sat_c_reg <= sat_b_reg;
        end
    end

endmodule

// ----- hw/rtl/rgb_ordered_dither.sv -----
// ----------------------------------------------------------------------------
// rgb_ordered_dither: multilevel 8x8 ordered dither of rgb pixels
// Three channel lanes in a stalling pipeline, a shared column counter and
// threshold lookup, and an output register that merges the lanes.
// ----------------------------------------------------------------------------
// One pixel item can be taken every clock unless the pipeline holds, and its
// result is offered from the output register: the accepting edge loads the first
// of three lane register stages, and the output register follows them.
// While the output item waits to be taken the whole pipeline holds and pixel
// ready stays low. After a level_count write the spacing reciprocal is
// recomputed by a bit-serial divider, one quotient bit a cycle, and pixel
// ready stays low while it runs.
module rgb_ordered_dither (
    input  logic                        clk,
    input  logic                        rst_n,
    rod_pix_if.sink                     pixel,
    rod_res_if.source                   result,
    input  logic                        cfg_we,
    input  logic [rod_pkg::LVL_W-1:0]   cfg_wdata
);

    logic [rod_pkg::LVL_W-1:0]    level_count_reg, level_count_next;
    logic [rod_pkg::PHASE_W-1:0]  phase_reg, phase_next;
    logic [rod_pkg::PHASE_W-1:0]  phase_sel;
    logic [rod_pkg::THR_W-1:0]    thr;
    logic                         v_a_reg, v_b_reg, v_c_reg, out_valid_reg;
    logic                         adv, accept;
    rod_pkg::recip_stat_t         stat;
    rod_pkg::lane_cfg_t           lane_cfg;
    logic [rod_pkg::DIV_W-1:0]    div_cur;
    logic [rod_pkg::CH_W-1:0]     red_lvl, green_lvl, blue_lvl;
    logic [rod_pkg::CH_W-1:0]     red_out_reg, green_out_reg, blue_out_reg;

    assign adv    = !out_valid_reg || result.ready;
    assign accept = pixel.valid && pixel.ready;
    assign pixel.ready = adv && !stat.busy;

    assign div_cur        = rod_pkg::eff_div(level_count_reg);
    assign lane_cfg.div   = div_cur;
    assign lane_cfg.recip = stat.recip;

    assign level_count_next = cfg_we ? cfg_wdata : level_count_reg;

    always_comb
    begin
        phase_sel = pixel.first_of_row
                  ? rod_pkg::PHASE_W'(pixel.start_col - rod_pkg::COL_W'(1))
                  : phase_reg;
        thr        = rod_pkg::THRESH[pixel.row][phase_sel];
        // columns run right to left, wrapping from one to eight
        phase_next = accept ? phase_sel - rod_pkg::PHASE_W'(1) : phase_reg;
    end

    rod_recip u_recip (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we),
        .div   (rod_pkg::eff_div(cfg_wdata)),
        .stat  (stat)
    );

    rod_lane u_lane_red (
        .clk   (clk),
        .en    (adv),
        .cfg   (lane_cfg),
        .chan  (pixel.red),
        .thr   (thr),
        .level (red_lvl)
    );

    rod_lane u_lane_green (
        .clk   (clk),
        .en    (adv),
        .cfg   (lane_cfg),
        .chan  (pixel.green),
        .thr   (thr),
        .level (green_lvl)
    );

    rod_lane u_lane_blue (
        .clk   (clk),
        .en    (adv),
        .cfg   (lane_cfg),
        .chan  (pixel.blue),
        .thr   (thr),
        .level (blue_lvl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_count_reg <= rod_pkg::LEVELS_RESET;
            phase_reg       <= '0;
            v_a_reg         <= 1'b0;
            v_b_reg         <= 1'b0;
            v_c_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            level_count_reg <= level_count_next;
            phase_reg       <= phase_next;
            if (adv)
            begin
                v_a_reg       <= accept;
                v_b_reg       <= v_a_reg;
                v_c_reg       <= v_b_reg;
                out_valid_reg <= v_c_reg;
            end
        end
    end

    // merge the three lanes into the output item
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_out_reg   <= red_lvl;
            green_out_reg <= green_lvl;
            blue_out_reg  <= blue_lvl;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.red_out   = red_out_reg;
    assign result.green_out = green_out_reg;
    assign result.blue_out  = blue_out_reg;

`ifndef SYNTHESIS
    a_cfg_starts_recip: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> stat.busy)
        else $error("level count write did not start the reciprocal unit");

    a_recip_exact: assert property (@(posedge clk) disable iff (!rst_n)
        !stat.busy |->
            ((34'(stat.recip) * 34'(div_cur)) >= (34'd1 << rod_pkg::PROD_SHIFT)) &&
            ((34'(stat.recip) * 34'(div_cur)) <
                ((34'd1 << rod_pkg::PROD_SHIFT) + 34'(div_cur))))
        else $error("spacing reciprocal does not match the level count");

    a_result_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(v_c_reg))
        else $error("output item without an item in the last lane stage");
`endif

endmodule
